// ----- rtl/tlul_pkg.sv -----
// Shared types and constants for the two-level TLB.
// No dependencies; used by every other file of the block but tlul_table.
package tlul_pkg;

  localparam int VA_W    = 32;
  localparam int PA_W    = 32;
  localparam int FRAME_W = 20;
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;
  localparam int NUM_CNT = 6;

  // command codes (s_tuser)
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_INVAL     = 1'b1;

  // result kind codes (m_tuser)
  localparam logic [1:0] LVL_L1    = 2'd0;
  localparam logic [1:0] LVL_L2    = 2'd1;
  localparam logic [1:0] LVL_MISS  = 2'd2;
  localparam logic [1:0] LVL_INVAL = 2'd3;

  // event counter slots
  localparam int CNT_L1_HIT   = 0;
  localparam int CNT_L1_MISS  = 1;
  localparam int CNT_L1_INVAL = 2;
  localparam int CNT_L2_HIT   = 3;
  localparam int CNT_L2_MISS  = 4;
  localparam int CNT_L2_INVAL = 5;

  // table write operations
  typedef logic [1:0] op_t;
  localparam op_t OP_NONE  = 2'd0;
  localparam op_t OP_TOUCH = 2'd1;
  localparam op_t OP_FILL  = 2'd2;
  localparam op_t OP_MARK  = 2'd3;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_go;
    logic scan_sel;   // 0 near table, 1 far table
    logic sweep;
    op_t  near_op;
    op_t  far_op;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic scan_done;
    logic is_inval;
    logic e_found;
    logic f_found;
    logic mark_need;
    logic out_busy;
  } ctrl_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- rtl/tlul_table.sv -----
// One TLB level store: single write port, one registered read port.
// No package dependencies.
module tlul_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 86
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tlul_dp.sv -----
// Datapath: request registers, both TLB stores, scan trackers, counters and
// the result register. Uses tlul_pkg and tlul_table.
module tlul_dp #(
  parameter int NEAR_ENTRIES = 16,
  parameter int FAR_ENTRIES  = 64,
  parameter int OFFSET_BITS  = 12,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tlul_pkg::ctrl_cmd_t   cmd,
  output tlul_pkg::ctrl_sts_t   sts,
  input  logic                  s_tuser,
  input  logic [79:0]           s_tdata,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [1:0]            m_tuser,
  output logic [223:0]          m_tdata
);

  localparam int PW   = ADDRESS_BITS - OFFSET_BITS;
  localparam int NIW  = $clog2(NEAR_ENTRIES);
  localparam int FIW  = $clog2(FAR_ENTRIES);
  localparam int MAXD = (NEAR_ENTRIES > FAR_ENTRIES) ? NEAR_ENTRIES : FAR_ENTRIES;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int EW   = 2 + PW + tlul_pkg::FRAME_W + tlul_pkg::STAMP_W;

  typedef struct packed {
    logic                          valid;
    logic                          dirty;
    logic [PW-1:0]                 page;
    logic [tlul_pkg::FRAME_W-1:0]  frame;
    logic [tlul_pkg::STAMP_W-1:0]  stamp;
  } entry_t;

  // input unpack
  logic [63:0] va_ext, ip_ext;
  assign va_ext = {32'b0, s_tdata[31:0]};
  assign ip_ext = {44'b0, s_tdata[72:53]};

  // request registers
  logic                          inval_r, wr_r;
  logic [PW-1:0]                 page_r;
  logic [OFFSET_BITS-1:0]        offs_r;
  logic [tlul_pkg::FRAME_W-1:0]  walk_r;
  logic [tlul_pkg::STAMP_W-1:0]  now_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_r <= '0;
    end else if (cmd.load) begin
      now_r <= now_r + tlul_pkg::STAMP_W'(1);
    end
    if (cmd.load) begin
      inval_r <= (s_tuser == tlul_pkg::CMD_INVAL);
      page_r  <= (s_tuser == tlul_pkg::CMD_INVAL) ? ip_ext[PW-1:0]
                                                  : va_ext[OFFSET_BITS +: PW];
      offs_r  <= va_ext[OFFSET_BITS-1:0];
      wr_r    <= s_tdata[32];
      walk_r  <= s_tdata[52:33];
    end
  end

  // scan pointer
  logic [CW-1:0] ptr, pidx, dep;
  logic          pv;
  assign dep = cmd.scan_sel ? CW'(FAR_ENTRIES) : CW'(NEAR_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      pv  <= 1'b0;
    end else if (cmd.scan_clr) begin
      ptr <= '0;
      pv  <= 1'b0;
    end else if (cmd.sweep) begin
      ptr <= ptr + CW'(1);
      pv  <= 1'b0;
    end else if (cmd.scan_go && ptr < dep) begin
      ptr <= ptr + CW'(1);
      pv  <= 1'b1;
    end else begin
      pv  <= 1'b0;
    end
    pidx <= ptr;
  end

  // stores
  logic           n_we, f_we;
  logic [NIW-1:0] n_waddr;
  logic [FIW-1:0] f_waddr;
  entry_t         n_wdata, f_wdata, nd, fd;
  logic [EW-1:0]  n_rd, f_rd;

  tlul_table #(.DEPTH(NEAR_ENTRIES), .WIDTH(EW)) u_near (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(ptr[NIW-1:0]), .rdata(n_rd)
  );
  tlul_table #(.DEPTH(FAR_ENTRIES), .WIDTH(EW)) u_far (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(ptr[FIW-1:0]), .rdata(f_rd)
  );

  assign nd = entry_t'(n_rd);
  assign fd = entry_t'(f_rd);

  logic n_proc, f_proc, n_match, f_match, g_match;
  assign n_proc  = pv && !cmd.scan_sel;
  assign f_proc  = pv && cmd.scan_sel;
  assign n_match = nd.valid && (nd.page == page_r);
  assign f_match = fd.valid && (fd.page == page_r);

  // trackers
  logic           e_found, nf_found, f_found, ff_found, g1_found, g2_found;
  logic [NIW-1:0] e_idx, nf_idx, nm_idx;
  logic [FIW-1:0] f_idx, ff_idx, fm_idx, g1_idx, g2_idx;
  entry_t         e_ent, nm_ent, f_ent, fm_ent, g1_ent, g2_ent;

  assign g_match = fd.valid && (fd.page == nm_ent.page);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_found  <= 1'b0;
      nf_found <= 1'b0;
      f_found  <= 1'b0;
      ff_found <= 1'b0;
      g1_found <= 1'b0;
      g2_found <= 1'b0;
    end else if (n_proc) begin
      if (n_match && !e_found) begin
        e_found <= 1'b1;
        e_idx   <= pidx[NIW-1:0];
        e_ent   <= nd;
      end
      if (!nd.valid && !nf_found) begin
        nf_found <= 1'b1;
        nf_idx   <= pidx[NIW-1:0];
      end
      if (pidx == '0 || nd.stamp < nm_ent.stamp) begin
        nm_idx <= pidx[NIW-1:0];
        nm_ent <= nd;
      end
    end else if (f_proc) begin
      if (f_match && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= pidx[FIW-1:0];
        f_ent   <= fd;
      end
      if (!fd.valid && !ff_found) begin
        ff_found <= 1'b1;
        ff_idx   <= pidx[FIW-1:0];
      end
      if (pidx == '0 || fd.stamp < fm_ent.stamp) begin
        fm_idx <= pidx[FIW-1:0];
        fm_ent <= fd;
      end
      // first two far copies of the near victim's page
      if (g_match && !g1_found) begin
        g1_found <= 1'b1;
        g1_idx   <= pidx[FIW-1:0];
        g1_ent   <= fd;
      end else if (g_match && !g2_found) begin
        g2_found <= 1'b1;
        g2_idx   <= pidx[FIW-1:0];
        g2_ent   <= fd;
      end
    end
  end

  // victims
  logic [NIW-1:0] nv_idx;
  logic [FIW-1:0] fv_idx, g_idx;
  logic           nv_mark, use_g2, g_found;
  entry_t         g_ent;
  assign nv_idx  = nf_found ? nf_idx : nm_idx;
  assign nv_mark = !nf_found && nm_ent.dirty;
  assign fv_idx  = ff_found ? ff_idx : fm_idx;
  // on a double miss the far fill happens first and may evict the first copy
  assign use_g2  = !f_found && g1_found && (g1_idx == fv_idx);
  assign g_found = use_g2 ? g2_found : g1_found;
  assign g_idx   = use_g2 ? g2_idx : g1_idx;
  assign g_ent   = use_g2 ? g2_ent : g1_ent;

  logic                         fill_dirty;
  logic [tlul_pkg::FRAME_W-1:0] fill_frame, res_frame;
  assign fill_dirty = f_found ? (f_ent.dirty || wr_r) : wr_r;
  assign fill_frame = f_found ? f_ent.frame : walk_r;
  assign res_frame  = e_found ? e_ent.frame : fill_frame;

  // near write port
  always_comb begin
    n_we    = 1'b0;
    n_waddr = ptr[NIW-1:0];
    n_wdata = '0;
    if (cmd.sweep) begin
      n_we = ptr < CW'(NEAR_ENTRIES);
    end else if (n_proc && inval_r && n_match) begin
      n_we    = 1'b1;
      n_waddr = pidx[NIW-1:0];
      n_wdata = nd;
      n_wdata.valid = 1'b0;
      n_wdata.dirty = 1'b0;
    end else begin
      case (cmd.near_op)
        tlul_pkg::OP_TOUCH: begin
          n_we    = 1'b1;
          n_waddr = e_idx;
          n_wdata = e_ent;
          n_wdata.stamp = now_r;
          n_wdata.dirty = e_ent.dirty || wr_r;
        end
        tlul_pkg::OP_FILL: begin
          n_we    = 1'b1;
          n_waddr = nv_idx;
          n_wdata = '{valid: 1'b1, dirty: fill_dirty, page: page_r,
                      frame: fill_frame, stamp: now_r};
        end
        default: begin
          n_we = 1'b0;
        end
      endcase
    end
  end

  // far write port
  always_comb begin
    f_we    = 1'b0;
    f_waddr = ptr[FIW-1:0];
    f_wdata = '0;
    if (cmd.sweep) begin
      f_we = ptr < CW'(FAR_ENTRIES);
    end else if (f_proc && inval_r && f_match) begin
      f_we    = 1'b1;
      f_waddr = pidx[FIW-1:0];
      f_wdata = fd;
      f_wdata.valid = 1'b0;
      f_wdata.dirty = 1'b0;
    end else begin
      case (cmd.far_op)
        tlul_pkg::OP_TOUCH: begin
          f_we    = 1'b1;
          f_waddr = f_idx;
          f_wdata = f_ent;
          f_wdata.stamp = now_r;
          f_wdata.dirty = f_ent.dirty || wr_r;
        end
        tlul_pkg::OP_FILL: begin
          f_we    = 1'b1;
          f_waddr = fv_idx;
          f_wdata = '{valid: 1'b1, dirty: wr_r, page: page_r,
                      frame: walk_r, stamp: now_r};
        end
        tlul_pkg::OP_MARK: begin
          f_we    = 1'b1;
          f_waddr = g_idx;
          f_wdata = g_ent;
          f_wdata.dirty = 1'b1;
        end
        default: begin
          f_we = 1'b0;
        end
      endcase
    end
  end

  // event counters
  logic [tlul_pkg::CNT_W-1:0] cnt      [tlul_pkg::NUM_CNT];
  logic [tlul_pkg::CNT_W-1:0] cnt_next [tlul_pkg::NUM_CNT];

  always_comb begin
    for (int k = 0; k < tlul_pkg::NUM_CNT; k++) begin
      cnt_next[k] = cnt[k];
    end
    if (n_proc && inval_r && n_match) begin
      cnt_next[tlul_pkg::CNT_L1_INVAL] = tlul_pkg::sat_inc(cnt[tlul_pkg::CNT_L1_INVAL]);
    end
    if (f_proc && inval_r && f_match) begin
      cnt_next[tlul_pkg::CNT_L2_INVAL] = tlul_pkg::sat_inc(cnt[tlul_pkg::CNT_L2_INVAL]);
    end
    if (cmd.finish && !inval_r) begin
      if (e_found) begin
        cnt_next[tlul_pkg::CNT_L1_HIT] = tlul_pkg::sat_inc(cnt[tlul_pkg::CNT_L1_HIT]);
      end else begin
        cnt_next[tlul_pkg::CNT_L1_MISS] = tlul_pkg::sat_inc(cnt[tlul_pkg::CNT_L1_MISS]);
        if (f_found) begin
          cnt_next[tlul_pkg::CNT_L2_HIT] = tlul_pkg::sat_inc(cnt[tlul_pkg::CNT_L2_HIT]);
        end else begin
          cnt_next[tlul_pkg::CNT_L2_MISS] = tlul_pkg::sat_inc(cnt[tlul_pkg::CNT_L2_MISS]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < tlul_pkg::NUM_CNT; k++) begin
      if (rst) begin
        cnt[k] <= '0;
      end else begin
        cnt[k] <= cnt_next[k];
      end
    end
  end

  // result register
  logic [63:0]             pa_w;
  logic [tlul_pkg::PA_W-1:0] pa;
  logic [1:0]              level;
  assign pa_w = ({44'b0, res_frame} << OFFSET_BITS) | {{(64 - OFFSET_BITS){1'b0}}, offs_r};
  assign pa   = inval_r ? '0 : pa_w[tlul_pkg::PA_W-1:0];
  assign level = inval_r ? tlul_pkg::LVL_INVAL :
                 e_found ? tlul_pkg::LVL_L1 :
                 f_found ? tlul_pkg::LVL_L2 : tlul_pkg::LVL_MISS;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.finish) begin
      m_tuser <= level;
      m_tdata <= {cnt_next[tlul_pkg::CNT_L2_INVAL], cnt_next[tlul_pkg::CNT_L2_MISS],
                  cnt_next[tlul_pkg::CNT_L2_HIT], cnt_next[tlul_pkg::CNT_L1_INVAL],
                  cnt_next[tlul_pkg::CNT_L1_MISS], cnt_next[tlul_pkg::CNT_L1_HIT], pa};
    end
  end

  assign sts.sweep_done = (ptr == CW'(MAXD));
  assign sts.scan_done  = (ptr == dep) && !pv;
  assign sts.is_inval   = inval_r;
  assign sts.e_found    = e_found;
  assign sts.f_found    = f_found;
  assign sts.mark_need  = nv_mark && g_found;
  assign sts.out_busy   = m_tvalid && !m_tready;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(m_tvalid && !m_tready))
    else $error("result overwritten while held");
  a_scan_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (ptr == '0) && !pv)
    else $error("scan pointer not restarted");
  a_mark_distinct: assert property (@(posedge clk) disable iff (rst)
    (cmd.far_op == tlul_pkg::OP_MARK) |-> !(f_found && g_idx == f_idx))
    else $error("dirty mark hits the touched far entry");
  a_cnt_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> cnt[tlul_pkg::CNT_L1_HIT] >= $past(cnt[tlul_pkg::CNT_L1_HIT]))
    else $error("hit counter went backwards");
`endif

endmodule

// ----- rtl/tlul_ctrl.sv -----
// Sequencer for the two-level TLB: clearing sweep, table scans, updates and
// result hand-off. Uses tlul_pkg command/status structs.
module tlul_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  tlul_pkg::ctrl_sts_t sts,
  output tlul_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN_N = 3'd2;
  localparam logic [2:0] ST_SCAN_F = 3'd3;
  localparam logic [2:0] ST_UPD1   = 3'd4;
  localparam logic [2:0] ST_UPD2   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        if (sts.sweep_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.sweep = 1'b1;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = ST_SCAN_N;
        end
      end
      ST_SCAN_N: begin
        cmd.scan_go = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_clr = 1'b1;
          state_next   = ST_SCAN_F;
        end
      end
      ST_SCAN_F: begin
        cmd.scan_go  = 1'b1;
        cmd.scan_sel = 1'b1;
        if (sts.scan_done) begin
          state_next = sts.is_inval ? ST_FIN : ST_UPD1;
        end
      end
      ST_UPD1: begin
        if (sts.e_found) begin
          cmd.near_op = tlul_pkg::OP_TOUCH;
          cmd.far_op  = sts.f_found ? tlul_pkg::OP_TOUCH : tlul_pkg::OP_NONE;
          state_next  = ST_FIN;
        end else begin
          cmd.near_op = tlul_pkg::OP_FILL;
          cmd.far_op  = sts.f_found ? tlul_pkg::OP_TOUCH : tlul_pkg::OP_FILL;
          state_next  = sts.mark_need ? ST_UPD2 : ST_FIN;
        end
      end
      ST_UPD2: begin
        cmd.far_op = tlul_pkg::OP_MARK;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/two_level_tlb_lru_unit.sv -----
// Top level of the two-level fully associative TLB with LRU replacement.
// Depends on tlul_pkg, tlul_ctrl, tlul_dp (which holds two tlul_table).
//
// Channels: s_* carries one request beat (translate or invalidate), m_* one
// result beat per request, carrying the physical address, the hit level and
// the six saturating event counters as they stand after that request.
// Sequence: a request scans the near table one entry a cycle, then the far
// table, spends state UPD1, and UPD2 when a dirty mark is due, on table
// updates (none for invalidate) and posts the result from state FIN.
// The block returns to idle before the next beat is taken. The scan reads
// one entry at a time since each level has a single table read port.
// One request is in flight at a time; s_tready is high only between
// requests, but a new request is taken while a result still waits on m_*.
// Reset: a clearing sweep over max(NEAR_ENTRIES, FAR_ENTRIES) entries wipes
// both stores; s_tready stays low until it ends. Counters and the access
// clock reset to zero.
// Stall: a result waits on m_* until m_tready; the next request then runs
// its scan and holds in its final step until the result register frees.
module two_level_tlb_lru_unit #(
  parameter int NEAR_ENTRIES = 16,
  parameter int FAR_ENTRIES  = 64,
  parameter int OFFSET_BITS  = 12,
  parameter int ADDRESS_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // vaddr[31:0], is_write[32],
                                  // walk_frame[52:33], inval_page[72:53], zero pad
  input  logic         s_tuser,   // command: 0 translate, 1 invalidate
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [223:0] m_tdata,   // physical_address[31:0], l1_hit_count,
                                  // l1_miss_count, l1_inval_count, l2_hit_count,
                                  // l2_miss_count, l2_inval_count (32 bits each)
  output logic [1:0]   m_tuser    // hit_level
);

  tlul_pkg::ctrl_cmd_t cmd;
  tlul_pkg::ctrl_sts_t sts;

  tlul_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .sts(sts), .cmd(cmd)
  );

  tlul_dp #(
    .NEAR_ENTRIES(NEAR_ENTRIES), .FAR_ENTRIES(FAR_ENTRIES),
    .OFFSET_BITS(OFFSET_BITS), .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tready(m_tready), .m_tvalid(m_tvalid),
    .m_tuser(m_tuser), .m_tdata(m_tdata)
  );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for two_level_tlb_lru_unit: drives translate and invalidate beats,
// predicts each result from a local two-level TLB model. Depends on tlul_pkg and the RTL.
module tb;

  localparam int NN = 16;
  localparam int FN = 64;
  localparam int OB = 12;
  localparam int PGW = 32 - OB;

  typedef struct {
    logic [31:0] pa;
    logic [1:0]  lvl;
    logic [31:0] cnt [tlul_pkg::NUM_CNT];
  } tlb_result_t;

  typedef struct {
    bit          valid;
    bit          dirty;
    logic [PGW-1:0] page;
    logic [19:0] frame;
  } tb_slot_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [223:0] m_tdata;
  logic [1:0] m_tuser;

  two_level_tlb_lru_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  // predictor state
  tb_slot_t    near_tab [NN];
  logic [63:0] near_st  [NN];
  tb_slot_t    far_tab  [FN];
  logic [63:0] far_st   [FN];
  logic [63:0] tick;
  logic [31:0] events [tlul_pkg::NUM_CNT];

  tlb_result_t pending_results [$];
  int errors = 0;
  int seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [PGW-1:0] hot_pages [8];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, seen);
  endtask

  function automatic void bump(input int k);
    if (events[k] != 32'hFFFF_FFFF) events[k] = events[k] + 1;
  endfunction

  function automatic int find_near(input logic [PGW-1:0] p);
    for (int i = 0; i < NN; i++) if (near_tab[i].valid && near_tab[i].page == p) return i;
    return -1;
  endfunction

  function automatic int find_far(input logic [PGW-1:0] p);
    for (int i = 0; i < FN; i++) if (far_tab[i].valid && far_tab[i].page == p) return i;
    return -1;
  endfunction

  function automatic int far_lru();
    int v;
    v = 0;
    for (int i = 0; i < FN; i++) if (!far_tab[i].valid) return i;
    for (int i = 1; i < FN; i++) if (far_st[i] < far_st[v]) v = i;
    return v;
  endfunction

  // near victim; a dirty evicted entry pushes its dirty mark into the far copy
  function automatic int near_evict();
    int v;
    int f;
    v = -1;
    for (int i = 0; i < NN; i++) if (v < 0 && !near_tab[i].valid) v = i;
    if (v < 0) begin
      v = 0;
      for (int i = 1; i < NN; i++) if (near_st[i] < near_st[v]) v = i;
    end
    if (near_tab[v].valid && near_tab[v].dirty) begin
      f = find_far(near_tab[v].page);
      if (f >= 0) far_tab[f].dirty = 1;
    end
    near_tab[v].valid = 0;
    return v;
  endfunction

  function automatic void clear_model();
    foreach (near_tab[i]) begin near_tab[i] = '{0, 0, '0, '0}; near_st[i] = '0; end
    foreach (far_tab[i]) begin far_tab[i] = '{0, 0, '0, '0}; far_st[i] = '0; end
    tick = '0;
    foreach (events[i]) events[i] = '0;
  endfunction

  function automatic tlb_result_t translate_predict(input logic cmd, input logic [31:0] va,
      input logic wr, input logic [19:0] wf, input logic [19:0] ip);
    tlb_result_t r;
    logic [PGW-1:0] pg;
    logic [19:0] fr;
    int e;
    int f;
    int v;
    tick = tick + 1;
    r.pa = '0;
    if (cmd == tlul_pkg::CMD_INVAL) begin
      pg = PGW'(ip);
      for (int i = 0; i < NN; i++)
        if (near_tab[i].valid && near_tab[i].page == pg) begin
          near_tab[i].valid = 0; near_tab[i].dirty = 0; bump(tlul_pkg::CNT_L1_INVAL);
        end
      for (int i = 0; i < FN; i++)
        if (far_tab[i].valid && far_tab[i].page == pg) begin
          far_tab[i].valid = 0; far_tab[i].dirty = 0; bump(tlul_pkg::CNT_L2_INVAL);
        end
      r.lvl = tlul_pkg::LVL_INVAL;
    end else begin
      pg = va[31:OB];
      e = find_near(pg);
      if (e >= 0) begin
        bump(tlul_pkg::CNT_L1_HIT);
        near_st[e] = tick;
        if (wr) near_tab[e].dirty = 1;
        f = find_far(pg);
        if (f >= 0) begin
          far_st[f] = tick;
          if (wr) far_tab[f].dirty = 1;
        end
        fr = near_tab[e].frame;
        r.lvl = tlul_pkg::LVL_L1;
      end else begin
        bump(tlul_pkg::CNT_L1_MISS);
        f = find_far(pg);
        if (f >= 0) begin
          bump(tlul_pkg::CNT_L2_HIT);
          far_st[f] = tick;
          if (wr) far_tab[f].dirty = 1;
          fr = far_tab[f].frame;
          v = near_evict();
          near_tab[v] = '{1, far_tab[f].dirty | wr, pg, fr};
          near_st[v] = tick;
          r.lvl = tlul_pkg::LVL_L2;
        end else begin
          bump(tlul_pkg::CNT_L2_MISS);
          fr = wf;
          v = far_lru();
          far_tab[v] = '{1, wr, pg, fr};
          far_st[v] = tick;
          v = near_evict();
          near_tab[v] = '{1, wr, pg, fr};
          near_st[v] = tick;
          r.lvl = tlul_pkg::LVL_MISS;
        end
      end
      r.pa = {fr, va[OB-1:0]};
    end
    foreach (events[i]) r.cnt[i] = events[i];
    return r;
  endfunction

  // one request beat; prediction is taken at acceptance
  task automatic send_request(input logic cmd, input logic [31:0] va, input logic wr,
      input logic [19:0] wf, input logic [19:0] ip);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {7'b0, ip, wf, wr, va};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(translate_predict(cmd, va, wr, wf, ip));
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    tlb_result_t w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen++;
        if (pending_results.size() == 0) begin
          report("unexpected beat", m_tdata[31:0], 32'h0);
        end else begin
          w = pending_results.pop_front();
          if (m_tdata[31:0] !== w.pa) report("physical_address", m_tdata[31:0], w.pa);
          if (m_tuser !== w.lvl) report("hit_level", 32'(m_tuser), 32'(w.lvl));
          for (int i = 0; i < tlul_pkg::NUM_CNT; i++)
            if (m_tdata[32*(i+1) +: 32] !== w.cnt[i])
              report($sformatf("counter %0d", i), m_tdata[32*(i+1) +: 32], w.cnt[i]);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] addr_of(input logic [PGW-1:0] p);
    return {p, OB'($urandom)};
  endfunction

  task automatic test_directed();
    send_request(tlul_pkg::CMD_TRANSLATE, 32'h0000_0000, 0, 20'h00000, 20'h0);
    send_request(tlul_pkg::CMD_TRANSLATE, 32'hFFFF_FFFF, 1, 20'hFFFFF, 20'hFFFFF);
    send_request(tlul_pkg::CMD_TRANSLATE, 32'h0000_0FFF, 0, 20'h12345, 20'h0);   // L1 hit
    send_request(tlul_pkg::CMD_TRANSLATE, 32'hFFFF_F000, 0, 20'h0, 20'h0); // L1 hit, written
    // fill 17 pages so near evicts its oldest (page 0), which then hits in far
    for (int i = 1; i <= 17; i++)
      send_request(tlul_pkg::CMD_TRANSLATE, {20'(i), 12'hABC}, i[0], 20'(i * 3), 20'h0);
    send_request(tlul_pkg::CMD_TRANSLATE, 32'h0000_0123, 1, 20'h0, 20'h0); // L2 hit, promote
    send_request(tlul_pkg::CMD_INVAL, 32'h0, 0, 20'h0, 20'h00005);          // both levels
    send_request(tlul_pkg::CMD_INVAL, 32'h0, 0, 20'h0, 20'h77777);          // no match
    send_request(tlul_pkg::CMD_TRANSLATE, 32'h0000_5000, 0, 20'hAAAAA, 20'h0); // miss again
  endtask

  task automatic test_random(input int n);
    int k;
    logic [PGW-1:0] p;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      // mostly a small hot set of pages so hits, promotions and evictions all happen
      p = (k < 70) ? hot_pages[$urandom_range(7)] ^ PGW'($urandom_range(23)) : PGW'($urandom);
      if (k < 88)
        send_request(tlul_pkg::CMD_TRANSLATE, addr_of(p), 1'($urandom_range(1)),
                     20'($urandom), 20'($urandom));
      else
        send_request(tlul_pkg::CMD_INVAL, $urandom, 1'($urandom_range(1)), 20'($urandom),
                     (k < 96) ? 20'(p) : 20'($urandom));
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    clear_model();
    foreach (hot_pages[i]) hot_pages[i] = PGW'($urandom);
    repeat (6) @(posedge clk);
    rst <= 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    test_directed();
    test_random(150);
    send_idle_pct = 45; recv_stall_pct = 0;
    test_random(170);
    send_idle_pct = 0; recv_stall_pct = 45;
    test_random(170);
    send_idle_pct = 35; recv_stall_pct = 35;
    test_random(170);
    drain();
    $display("covered %0d results: L1/L2 hits, misses, promotions, evictions, invalidates",
             seen);
    $display("under no idling, sender gaps, receiver stalls and both");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // about 700 requests, stalls included, finish well under this bound
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
